>>> hw/rtl/page_span_allocator_defines.svh
// Assertion macros for the page span allocator checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef PAGE_SPAN_ALLOCATOR_DEFINES_SVH
`define PAGE_SPAN_ALLOCATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PSA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page span allocator check failed");

// Consequent checked in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page span allocator check failed");

`endif

>>> hw/rtl/psa_pkg.sv
// Shared types and constants of the page span allocator.
// Used by the top level and by its checker; depends on nothing.
`default_nettype none

package psa_pkg;

    localparam int PAGES_W     = 8;
    localparam int FIRST_W     = 20;
    localparam int STATUS_W    = 2;
    localparam int BASE_W      = 20;
    localparam int LIMIT_W     = 14;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 20;

    localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RESET = LIMIT_W'(8192);

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DROPPED   = 2'd2
    } t_status;

endpackage

`default_nettype wire

>>> hw/rtl/page_span_allocator.sv
// Page span allocator: grants spans of contiguous pages from per-length free stacks.
// Depends on psa_pkg for field widths, register indexes and status codes.
`default_nettype none

// Channel     Direction  Handshake                 Word
// request     in         start & !busy             i_pages_requested
// result      out        o_valid, one cycle only   o_span_first_page, o_span_pages,
//                                                  o_alloc_status
// config      in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// From accept to result a request goes through these steps: the accept folds the
// non-empty flags into sixteen-wide groups, then come the group pick with two fill
// reads, the pop with the span store read, and the write-back of the remainder.
// busy stays high in S_SRCH, S_POP and S_FIN; the strobe shows as busy falls, and
// the next request may be accepted in that very cycle.
// Reset is synchronous and active low and empties every stack through the non-empty
// flags, so no clearing pass is needed; the receiver cannot stall.

module page_span_allocator #(
    parameter int MAX_SPAN_PAGES = 128,
    parameter int STACK_DEPTH    = 16,
    parameter int PAGE_ID_BITS   = 20
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [psa_pkg::PAGES_W-1:0]       i_pages_requested,
    output logic                              o_valid,
    output logic [psa_pkg::FIRST_W-1:0]       o_span_first_page,
    output logic [psa_pkg::PAGES_W-1:0]       o_span_pages,
    output logic [psa_pkg::STATUS_W-1:0]      o_alloc_status,
    input  wire                               i_cfg_we,
    input  wire  [psa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [psa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import psa_pkg::*;

    // Stack index, clamped length, fill count and span store address widths.
    localparam int SW            = (MAX_SPAN_PAGES > 1) ? $clog2(MAX_SPAN_PAGES) : 1;
    localparam int KW            = $clog2(MAX_SPAN_PAGES + 1);
    localparam int FW            = $clog2(STACK_DEPTH + 1);
    localparam int STORE_ENTRIES = MAX_SPAN_PAGES * STACK_DEPTH;
    localparam int AW            = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;

    // The stack search runs in two registered levels: groups of sixteen flags,
    // then a pick among the MAX_SPAN_PAGES / 16 groups, rounded up.
    localparam int GRP_W = 16;
    localparam int GOW   = 4;
    localparam int NG    = (MAX_SPAN_PAGES + GRP_W - 1) / GRP_W;
    localparam int GIW   = (NG > 1) ? $clog2(NG) : 1;

    // Chunk page ids are summed wide enough that nothing is lost before the wrap.
    localparam int SUMW  = LIMIT_W + KW + 1;
    localparam int WW0   = (PAGE_ID_BITS > SUMW) ? PAGE_ID_BITS : SUMW;
    localparam int WW    = (WW0 > FIRST_W) ? WW0 : FIRST_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SRCH,
        S_POP,
        S_FIN
    } t_state;

    t_state                     r_state;

    // Configuration and allocator bookkeeping.
    logic [BASE_W-1:0]          r_pool_base;
    logic [LIMIT_W-1:0]         r_chunk_limit;
    logic [LIMIT_W-1:0]         r_chunks;
    logic [MAX_SPAN_PAGES-1:0]  r_nonempty;

    // Memories: fill count per stack, and the span store proper.
    logic [FW-1:0]              r_fill_mem  [MAX_SPAN_PAGES];
    logic [PAGE_ID_BITS-1:0]    r_store_mem [STORE_ENTRIES];

    // Per-request working registers.
    logic [KW-1:0]              r_k;
    logic [NG-1:0]              r_grp_any;
    logic [GOW-1:0]             r_grp_off [NG];
    logic [SW-1:0]              r_s;
    logic [SW-1:0]              r_rem_idx;
    logic                       r_found;
    logic                       r_rem_need;
    logic                       r_ok;
    logic [FW-1:0]              r_fill_a;
    logic [FW-1:0]              r_fill_b;
    logic                       r_fb_v;
    logic [PAGE_ID_BITS-1:0]    r_store_rd;
    logic [PAGE_ID_BITS-1:0]    r_chunk_first;

    // Result registers.
    logic                       r_valid;
    logic [FIRST_W-1:0]         r_first;
    logic [PAGES_W-1:0]         r_pages;
    t_status                    r_status;

    // Combinational signals.
    logic [KW-1:0]              k_clamp;
    logic [NG*GRP_W-1:0]        m_flags;
    logic [NG-1:0]              grp_any;
    logic [GOW-1:0]             grp_off [NG];
    logic                       hit;
    logic [GIW-1:0]             gsel;
    logic [SW-1:0]              s_sel;
    logic [SW-1:0]              rem_idx;
    logic                       rem_need;
    logic [FW-1:0]              fa_dec;
    logic [AW-1:0]              pop_addr;
    logic [WW-1:0]              chunk_wide;
    logic [PAGE_ID_BITS-1:0]    first;
    logic [PAGE_ID_BITS-1:0]    rem_first;
    logic [FW-1:0]              fb;
    logic                       room;
    logic                       push;
    logic [AW-1:0]              push_addr;
    logic                       fill_we;
    logic [SW-1:0]              fill_waddr;
    logic [FW-1:0]              fill_wdata;
    t_state                     n_state;

    assign busy              = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_span_first_page = r_first;
    assign o_span_pages      = r_pages;
    assign o_alloc_status    = r_status;

    // A request of zero pages counts as one page; anything above the
    // largest span is served as the largest span.
    always_comb begin
        logic [PAGES_W:0] k_ext;
        k_ext = {1'b0, i_pages_requested};
        if (k_ext == '0) begin
            k_clamp = KW'(1);
        end else if (int'(k_ext) > MAX_SPAN_PAGES) begin
            k_clamp = KW'(MAX_SPAN_PAGES);
        end else begin
            k_clamp = KW'(k_ext);
        end
    end

    // First search level: stacks long enough for the request that hold a
    // span, folded into a flag and a lowest offset per group.
    always_comb begin
        m_flags = '0;
        for (int j = 0; j < MAX_SPAN_PAGES; j++) begin
            m_flags[j] = r_nonempty[j] && ((j + 1) >= int'(k_clamp));
        end
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = |m_flags[g*GRP_W +: GRP_W];
            grp_off[g] = '0;
            for (int b = GRP_W - 1; b >= 0; b--) begin
                if (m_flags[g*GRP_W + b]) begin
                    grp_off[g] = GOW'(b);
                end
            end
        end
    end

    // Second search level: lowest group with a hit. With no hit the request
    // is carved from a fresh chunk, which behaves like the longest stack.
    always_comb begin
        hit  = 1'b0;
        gsel = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                hit  = 1'b1;
                gsel = GIW'(g);
            end
        end
        s_sel    = hit ? SW'(int'(gsel) * GRP_W + int'(r_grp_off[gsel]))
                       : SW'(MAX_SPAN_PAGES - 1);
        rem_need = int'(s_sel) >= int'(r_k);
        rem_idx  = SW'(int'(s_sel) - int'(r_k));
    end

    // Pop side and chunk carving.
    always_comb begin
        fa_dec     = r_fill_a - FW'(1);
        pop_addr   = AW'(int'(r_s) * STACK_DEPTH + int'(fa_dec));
        chunk_wide = WW'(r_pool_base) + WW'(r_chunks) * WW'(MAX_SPAN_PAGES);
    end

    // Push side: the remainder goes onto its stack unless that stack is full.
    always_comb begin
        first     = r_found ? r_store_rd : r_chunk_first;
        rem_first = PAGE_ID_BITS'(WW'(first) + WW'(r_k));
        fb        = r_fb_v ? r_fill_b : '0;
        room      = int'(fb) < STACK_DEPTH;
        push      = (r_state == S_FIN) && r_ok && r_rem_need && room;
        push_addr = AW'(int'(r_rem_idx) * STACK_DEPTH + int'(fb));
    end

    // One write port on the fill memory: the pop writes in S_POP and the
    // remainder push in S_FIN, so the two never meet.
    always_comb begin
        fill_we    = 1'b0;
        fill_waddr = r_s;
        fill_wdata = fa_dec;
        if (r_state == S_POP && r_found) begin
            fill_we = 1'b1;
        end else if (push) begin
            fill_we    = 1'b1;
            fill_waddr = r_rem_idx;
            fill_wdata = fb + FW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH:  n_state = S_POP;
            S_POP:   n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Fill memory: two registered reads in S_SRCH, one write.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SRCH) begin
            r_fill_a <= r_fill_mem[s_sel];
            r_fill_b <= r_fill_mem[rem_idx];
        end
        if (fill_we) begin
            r_fill_mem[fill_waddr] <= fill_wdata;
        end
    end

    // Span store: registered read in S_POP, write in S_FIN.
    always_ff @(posedge i_clk) begin
        if (r_state == S_POP) begin
            r_store_rd <= r_store_mem[pop_addr];
        end
        if (push) begin
            r_store_mem[push_addr] <= rem_first;
        end
    end

    // Payload registers of the request in flight.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_k       <= k_clamp;
                r_grp_any <= grp_any;
                for (int g = 0; g < NG; g++) begin
                    r_grp_off[g] <= grp_off[g];
                end
            end
            S_SRCH: begin
                r_s        <= s_sel;
                r_rem_idx  <= rem_idx;
                r_found    <= hit;
                r_rem_need <= rem_need;
                r_fb_v     <= r_nonempty[rem_idx];
            end
            S_POP: begin
                r_ok          <= r_found || (r_chunks < r_chunk_limit);
                r_chunk_first <= PAGE_ID_BITS'(chunk_wide);
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // Control state, bookkeeping and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pool_base   <= '0;
            r_chunk_limit <= CHUNK_LIMIT_RESET;
            r_chunks      <= '0;
            r_nonempty    <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_FIN);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_POOL_BASE:   r_pool_base   <= i_cfg_data[BASE_W-1:0];
                    CFG_CHUNK_LIMIT: r_chunk_limit <= i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == S_POP) begin
                if (r_found) begin
                    r_nonempty[r_s] <= (fa_dec != '0);
                end else if (r_chunks < r_chunk_limit) begin
                    r_chunks <= r_chunks + LIMIT_W'(1);
                end
            end

            if (push) begin
                r_nonempty[r_rem_idx] <= 1'b1;
            end

            if (r_state == S_FIN) begin
                if (r_ok) begin
                    r_first  <= FIRST_W'(WW'(first));
                    r_pages  <= PAGES_W'(r_k);
                    r_status <= (r_rem_need && !room) ? ST_DROPPED : ST_GRANTED;
                end else begin
                    r_first  <= '0;
                    r_pages  <= '0;
                    r_status <= ST_EXHAUSTED;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psa_checker.sv
// Port-level checker for the page span allocator, bound to the top level.
// Depends on psa_pkg and on the macros in page_span_allocator_defines.svh.
`default_nettype none

`include "page_span_allocator_defines.svh"

module psa_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            start,
    input wire                            busy,
    input wire                            o_valid,
    input wire [psa_pkg::FIRST_W-1:0]     o_span_first_page,
    input wire [psa_pkg::PAGES_W-1:0]     o_span_pages,
    input wire [psa_pkg::STATUS_W-1:0]    o_alloc_status
);

    import psa_pkg::*;

    // Every accepted request yields its result word.
    `PSA_ASSERT_SAME(a_result_after_accept, start && !busy, ##4 o_valid)

    // The strobe lasts a single cycle.
    `PSA_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid)

    // A result only shows once the block has gone idle.
    `PSA_ASSERT_SAME(a_idle_on_result, o_valid, !busy)

    // An exhausted pool grants nothing.
    `PSA_ASSERT_SAME(a_exhausted_zero, o_valid && (o_alloc_status == ST_EXHAUSTED), (o_span_first_page == '0) && (o_span_pages == '0))

endmodule

bind page_span_allocator psa_checker u_psa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_span_first_page (o_span_first_page),
    .o_span_pages      (o_span_pages),
    .o_alloc_status    (o_alloc_status)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_span_allocator: a directed part, then random request words.
// Depends on psa_pkg and the page_span_allocator RTL; a built-in span model predicts each grant.

module tb;

    import psa_pkg::*;

    localparam int MAX_SPAN_PAGES = 128;
    localparam int STACK_DEPTH    = 16;
    localparam int PAGE_ID_BITS   = 20;
    localparam int RANDOM_ITEMS   = 1026;
    localparam int RANDOM_PHASES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    // One expected grant, laid out like the result ports.
    typedef struct packed {
        logic [FIRST_W-1:0] first;
        logic [PAGES_W-1:0] pages;
        t_status            status;
    } t_span_grant;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [PAGES_W-1:0]    i_pages_requested;
    logic                  o_valid;
    logic [FIRST_W-1:0]    o_span_first_page;
    logic [PAGES_W-1:0]    o_span_pages;
    logic [STATUS_W-1:0]   o_alloc_status;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Span model state: one LIFO of free first-page ids per span length.
    logic [FIRST_W-1:0] free_stack [MAX_SPAN_PAGES][STACK_DEPTH];
    int                 free_fill  [MAX_SPAN_PAGES];
    int                 chunks_carved;
    logic [BASE_W-1:0]  pool_base;
    logic [LIMIT_W-1:0] chunk_limit;

    t_span_grant pending_grants[$];
    t_span_grant head_grant;
    logic [PAGES_W-1:0] last_request;

    int mismatch_count;
    int n_sent;
    int n_checked;
    int n_exhausted;
    int n_dropped;
    int idle_count;

    page_span_allocator #(
        .MAX_SPAN_PAGES (MAX_SPAN_PAGES),
        .STACK_DEPTH    (STACK_DEPTH),
        .PAGE_ID_BITS   (PAGE_ID_BITS)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_pages_requested (i_pages_requested),
        .o_valid           (o_valid),
        .o_span_first_page (o_span_first_page),
        .o_span_pages      (o_span_pages),
        .o_alloc_status    (o_alloc_status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Works out the grant for one accepted request and updates the span model.
    // Lengths of zero are served as one page, and lengths above the chunk size are
    // served as a whole chunk.
    function automatic t_span_grant predict_grant(input logic [PAGES_W-1:0] req);
        int                 k;
        int                 len;
        int                 rem;
        logic [FIRST_W-1:0] first;
        t_status            status;
        t_span_grant        g;
        k = int'(req);
        if (k == 0) begin
            k = 1;
        end
        if (k > MAX_SPAN_PAGES) begin
            k = MAX_SPAN_PAGES;
        end
        len = 0;
        for (int i = k; i <= MAX_SPAN_PAGES; i++) begin
            if (free_fill[i-1] != 0) begin
                len = i;
                break;
            end
        end
        if (len != 0) begin
            free_fill[len-1]--;
            first = free_stack[len-1][free_fill[len-1]];
        end else if (chunks_carved < int'(chunk_limit)) begin
            // Fresh chunk ids wrap modulo the page id space.
            first = FIRST_W'(pool_base + chunks_carved * MAX_SPAN_PAGES);
            chunks_carved++;
            len = MAX_SPAN_PAGES;
        end else begin
            // Out of pool: nothing in the model changes.
            n_exhausted++;
            g.first  = '0;
            g.pages  = '0;
            g.status = ST_EXHAUSTED;
            return g;
        end
        status = ST_GRANTED;
        if (len > k) begin
            rem = len - k;
            if (free_fill[rem-1] >= STACK_DEPTH) begin
                // The tail is lost, but the grant itself stands.
                status = ST_DROPPED;
                n_dropped++;
            end else begin
                free_stack[rem-1][free_fill[rem-1]] = FIRST_W'(first + k);
                free_fill[rem-1]++;
            end
        end
        g.first  = first;
        g.pages  = PAGES_W'(k);
        g.status = status;
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t, result %0d: %s got %0d, expected %0d",
                 $realtime, n_checked, what, got, want);
        mismatch_count++;
    endtask

    // Result checker. The strobe lasts exactly one cycle and cannot be stalled,
    // so every high cycle is one result word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                report_mismatch("unexpected result word, first page",
                                32'(o_span_first_page), 32'd0);
            end else begin
                head_grant = pending_grants.pop_front();
                if (o_span_first_page !== head_grant.first) begin
                    report_mismatch("span_first_page", 32'(o_span_first_page),
                                    32'(head_grant.first));
                end
                if (o_span_pages !== head_grant.pages) begin
                    report_mismatch("span_pages", 32'(o_span_pages), 32'(head_grant.pages));
                end
                if (o_alloc_status !== head_grant.status) begin
                    report_mismatch("alloc_status", 32'(o_alloc_status),
                                    32'(head_grant.status));
                end
            end
            n_checked++;
        end
    end

    // Watchdog: any accepted request, result word or register write counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || i_cfg_we) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, pending_grants.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reset_block();
        i_rst_n = 1'b0;
        for (int s = 0; s < MAX_SPAN_PAGES; s++) begin
            free_fill[s] = 0;
        end
        chunks_carved = 0;
        pool_base     = '0;
        chunk_limit   = CHUNK_LIMIT_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Offers one request word and holds it until the block takes it.
    task automatic send_request(input logic [PAGES_W-1:0] pages);
        @(negedge i_clk);
        start             <= 1'b1;
        i_pages_requested <= pages;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pending_grants.push_back(predict_grant(pages));
        last_request = pages;
        n_sent++;
    endtask

    task automatic pause_requests(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Every request yields a result, so the block is idle once none is due.
    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_grants.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_POOL_BASE) begin
            pool_base = data[BASE_W-1:0];
        end else begin
            chunk_limit = data[LIMIT_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Request lengths at the field extremes, with a pool base that makes the
    // second chunk wrap past the top of the page id space.
    task automatic test_length_extremes();
        write_register(CFG_POOL_BASE, CFG_DATA_W'(20'hFFF80));
        write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(CHUNK_LIMIT_RESET));
        send_request(8'd255);
        send_request(8'd0);
        send_request(8'd128);
        send_request(8'd129);
        send_request(8'd127);
        wait_for_results();
    endtask

    // Each 127-page request splits a fresh chunk and leaves a one-page tail; the
    // seventeenth tail finds its stack full and is dropped.
    task automatic test_remainder_drop();
        repeat (STACK_DEPTH + 1) send_request(8'd127);
        wait_for_results();
    endtask

    // With the pool spent, a whole-chunk request fails while a one-page request
    // is still served from its stack.
    task automatic test_pool_exhausted();
        write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(chunks_carved));
        send_request(8'd200);
        send_request(8'd1);
        wait_for_results();
    endtask

    function automatic logic [PAGES_W-1:0] pick_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            return PAGES_W'($urandom_range(1, 16));
        end else if (r < 60) begin
            // Long spans leave short tails that fill the small stacks.
            return PAGES_W'($urandom_range(112, 128));
        end else if (r < 80) begin
            return PAGES_W'($urandom_range(1, 128));
        end else if (r < 90) begin
            return $urandom_range(0, 1) ? PAGES_W'(0) : PAGES_W'($urandom_range(129, 255));
        end else begin
            return last_request;
        end
    endfunction

    // Random phases, each under its own pool setting. The last phase runs with
    // no gaps between request words.
    task automatic test_random_phases();
        int per_phase;
        int count;
        int idle_pct;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0: write_register(CFG_POOL_BASE, '0);
                1: write_register(CFG_POOL_BASE, CFG_DATA_W'(20'hFFFFF));
                default: write_register(CFG_POOL_BASE, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
            endcase
            case (p == 1 ? 1 : $urandom_range(0, 4))
                0: write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(CHUNK_LIMIT_RESET));
                1: write_register(CFG_CHUNK_LIMIT, '0);
                2: write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(chunks_carved + $urandom_range(1, 6)));
                3: write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'($urandom_range(0, 8192)));
                default: write_register(CFG_CHUNK_LIMIT, CFG_DATA_W'(CHUNK_LIMIT_RESET));
            endcase
            idle_pct = (p == RANDOM_PHASES - 1) ? 0 : 15 * $urandom_range(0, 3);
            count = (p == RANDOM_PHASES - 1) ? RANDOM_ITEMS - per_phase * p : per_phase;
            repeat (count) begin
                if ($urandom_range(1, 100) <= idle_pct) begin
                    pause_requests($urandom_range(1, 17));
                end
                send_request(pick_request());
            end
            wait_for_results();
        end
    endtask

    initial begin
        start             = 1'b0;
        i_pages_requested = '0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_POOL_BASE;
        i_cfg_data        = '0;
        mismatch_count    = 0;
        n_sent            = 0;
        n_checked         = 0;
        n_exhausted       = 0;
        n_dropped         = 0;
        idle_count        = 0;
        last_request      = 8'd1;

        reset_block();
        test_length_extremes();
        test_remainder_drop();
        test_pool_exhausted();
        test_random_phases();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d grants; %0d chunks carved,",
                 n_sent, n_checked, chunks_carved);
        $display("%0d requests found the pool spent, %0d tails were dropped, %0d mismatches.",
                 n_exhausted, n_dropped, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
